/* design/psmc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psmc_pkg: shared types, constants and helpers
// Coordinate and size types, packet framing types and clamp functions for
// the mouse cursor tracker.
// ----------------------------------------------------------------------------
package psmc_pkg;

    localparam int COORD_BITS = 13;
    localparam int SIZE_BITS  = 14;
    // wide enough for a size, a coordinate plus a 9-bit move, and a sign
    localparam int CALC_BITS  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

    typedef logic [COORD_BITS-1:0]       t_coord;
    typedef logic [SIZE_BITS-1:0]        t_size;
    typedef logic signed [CALC_BITS-1:0] t_calc;

    localparam t_calc COORD_MAX    = t_calc'((64'd1 << COORD_BITS) - 64'd1);
    localparam t_size RESET_WIDTH  = t_size'(1024);
    localparam t_size RESET_HEIGHT = t_size'(768);

    // register indexes on the config port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // header byte bit positions
    localparam int HDR_LEFT  = 0;
    localparam int HDR_RIGHT = 1;
    localparam int HDR_MID   = 2;
    localparam int HDR_SYNC  = 3;
    localparam int HDR_XSIGN = 4;
    localparam int HDR_YSIGN = 5;

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } t_phase;

    typedef struct packed {
        logic       done;
        logic [7:0] hdr;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_pkt;

    function automatic t_calc largest_coord(t_size size);
        t_calc m;
        if (size == '0) begin
            m = '0;
        end else begin
            m = t_calc'(size) - t_calc'(1);
        end
        if (m > COORD_MAX) begin
            m = COORD_MAX;
        end
        return m;
    endfunction

    function automatic t_coord clamp_coord(t_calc v, t_size size);
        t_calc m;
        t_calc r;
        m = largest_coord(size);
        if (v < 0) begin
            r = '0;
        end else if (v > m) begin
            r = m;
        end else begin
            r = v;
        end
        return t_coord'(r);
    endfunction

    function automatic t_coord recenter_coord(t_size size);
        return clamp_coord(t_calc'(size >> 1), size);
    endfunction

endpackage
`default_nettype wire

/* design/psmc_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psmc_framer: three-byte packet framer
// Tracks the packet phase on mouse bytes, holds the header and X byte, and
// flags the byte that completes a packet.
// ----------------------------------------------------------------------------
module psmc_framer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_aux,
    output psmc_pkg::t_pkt     o_pkt
);
    import psmc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_hdr;
    logic [7:0] r_x_byte;
    logic       w_mouse;

    assign w_mouse = i_vld && i_aux;

    always_comb begin
        n_phase = r_phase;
        if (w_mouse) begin
            case (r_phase)
                PH_X:    n_phase = PH_Y;
                PH_Y:    n_phase = PH_SYNC;
                default: n_phase = i_byte[HDR_SYNC] ? PH_X : PH_SYNC;
            endcase
        end
    end

    always_comb begin
        o_pkt.done   = w_mouse && (r_phase == PH_Y);
        o_pkt.hdr    = r_hdr;
        o_pkt.x_byte = r_x_byte;
        o_pkt.y_byte = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC;
            r_hdr    <= '0;
            r_x_byte <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            if (w_mouse) begin
                case (r_phase)
                    PH_X:    r_x_byte <= i_byte;
                    PH_Y:    ;
                    default: if (i_byte[HDR_SYNC]) r_hdr <= i_byte;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

/* design/psmc_cursor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psmc_cursor: cursor position keeper
// Applies the signed X/Y moves of a packet, Y inverted, clamped to the
// screen size; recenters on request.
// ----------------------------------------------------------------------------
module psmc_cursor (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_move,
    input  wire logic            i_recenter,
    input  wire psmc_pkg::t_pkt  i_pkt,
    input  wire psmc_pkg::t_size i_width,
    input  wire psmc_pkg::t_size i_height,
    output psmc_pkg::t_coord     o_next_x,
    output psmc_pkg::t_coord     o_next_y,
    output psmc_pkg::t_coord     o_pos_x,
    output psmc_pkg::t_coord     o_pos_y
);
    import psmc_pkg::*;

    t_coord r_pos_x, r_pos_y;
    t_calc  w_dx, w_dy;

    assign w_dx = t_calc'($signed({i_pkt.hdr[HDR_XSIGN], i_pkt.x_byte}));
    assign w_dy = t_calc'($signed({i_pkt.hdr[HDR_YSIGN], i_pkt.y_byte}));

    // screen row zero is at the top, so y moves the other way
    assign o_next_x = clamp_coord(t_calc'(r_pos_x) + w_dx, i_width);
    assign o_next_y = clamp_coord(t_calc'(r_pos_y) - w_dy, i_height);
    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= recenter_coord(RESET_WIDTH);
            r_pos_y <= recenter_coord(RESET_HEIGHT);
        end else if (i_recenter) begin
            r_pos_x <= recenter_coord(i_width);
            r_pos_y <= recenter_coord(i_height);
        end else if (i_move) begin
            r_pos_x <= o_next_x;
            r_pos_y <= o_next_y;
        end
    end

endmodule
`default_nettype wire

/* design/ps2_mouse_cursor_tracker.sv */
`default_nettype none
// Takes one byte per cycle, unless the input is stalled, from a PS/2 controller
// (keyboard bytes are dropped), frames mouse bytes into three-byte packets and
// emits one word per packet with the clamped cursor position and the three
// buttons. A byte is latched in an input register; framing and the position
// update run when the held byte moves on and load the result register, so a
// packet's word passes the input register and then the result register.
// The input stall follows the output stall only when the held byte finishes
// a packet and the result register is still occupied. A write to either
// screen size register sets a pending recenter flag, which recenters the cursor.
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker: PS/2 mouse cursor tracker
// Packet framer, cursor position keeper and config registers behind a
// valid/stall input and output stage.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic                 i_from_aux,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output psmc_pkg::t_coord          o_cursor_x,
    output psmc_pkg::t_coord          o_cursor_y,
    output logic                      o_left_button,
    output logic                      o_right_button,
    output logic                      o_middle_button,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import psmc_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_aux;
    logic       r_out_vld;
    t_coord     r_out_x, r_out_y;
    logic       r_out_left, r_out_right, r_out_mid;
    t_size      r_width, r_height;
    logic       r_recenter;

    logic   w_out_free, w_fire, w_accept, w_cfg_wr;
    t_pkt   w_pkt;
    t_coord w_next_x, w_next_y, w_pos_x, w_pos_y;

    psmc_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_step  (w_fire),
        .i_byte  (r_in_byte),
        .i_aux   (r_in_aux),
        .o_pkt   (w_pkt)
    );

    psmc_cursor u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_move     (w_fire && w_pkt.done),
        .i_recenter (r_recenter),
        .i_pkt      (w_pkt),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_next_x   (w_next_x),
        .o_next_y   (w_next_y),
        .o_pos_x    (w_pos_x),
        .o_pos_y    (w_pos_y)
    );

    // held byte moves on unless it finishes a packet and the result slot is full and stalled
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && (!w_pkt.done || w_out_free);
    assign o_in_stall = r_in_vld && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
            r_in_aux  <= i_from_aux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_pkt.done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_pkt.done) begin
            r_out_x     <= w_next_x;
            r_out_y     <= w_next_y;
            r_out_left  <= w_pkt.hdr[HDR_LEFT];
            r_out_right <= w_pkt.hdr[HDR_RIGHT];
            r_out_mid   <= w_pkt.hdr[HDR_MID];
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_cursor_x      = r_out_x;
    assign o_cursor_y      = r_out_y;
    assign o_left_button   = r_out_left;
    assign o_right_button  = r_out_right;
    assign o_middle_button = r_out_mid;

    // config registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RESET_WIDTH;
            r_height   <= RESET_HEIGHT;
            r_recenter <= 1'b0;
        end else begin
            r_recenter <= w_cfg_wr;
            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_WIDTH:  r_width  <= pwdata[SIZE_BITS-1:0];
                    REG_HEIGHT: r_height <= pwdata[SIZE_BITS-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    // a completed packet always lands in the result register
    a_pkt_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_pkt.done) |=> o_out_valid)
        else $error("completed packet did not produce a result word");

    // kept position stays on screen except while a recenter is pending
    a_pos_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_recenter |-> (t_calc'(w_pos_x) <= largest_coord(r_width)))
        else $error("cursor x beyond screen width");

    a_pos_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_recenter |-> (t_calc'(w_pos_y) <= largest_coord(r_height)))
        else $error("cursor y beyond screen height");

    // a held byte that ends no packet never stalls the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_pkt.done) |-> !o_in_stall)
        else $error("input stalled on a byte that ends no packet");

endmodule
`default_nettype wire
